// ===== src/dhst_pkg.sv =====
`default_nettype none

package dhst_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_KEY_LEN_DEF = 255;

    localparam logic [31:0] DJB_SEED = 32'd5381;
    localparam int          CFG_W    = 13;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [11:0] entry_index;
        logic [31:0] entry_primary_hash;
        logic [31:0] entry_secondary_hash;
        logic [7:0]  key_byte;
        logic        key_last;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] match_index;
        logic [31:0] primary_hash;
        logic [31:0] secondary_hash;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/dual_hash_sorted_table_lookup.sv =====
`default_nettype none

// Load items and non-final key bytes are accepted while idle and produce no result.
// A final key byte starts a lookup; no item is accepted until its result is handed over.
// Each binary search step and each neighbour scanned issues a read, then compares the
// registered data; an empty search range or the end of the right-side scan ends the lookup
// as not found, and the hand-over to the output register waits until a held result is taken.
// Reset clears control state, accumulators and the entry count; the table is left undefined.
module dual_hash_sorted_table_lookup #(
    parameter int TABLE_DEPTH = dhst_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_LEN = dhst_pkg::MAX_KEY_LEN_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire dhst_pkg::in_item_t        s_data,
    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      dhst_pkg::out_item_t       m_data,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [dhst_pkg::CFG_W-1:0] cfg_data
);
    import dhst_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = NW + 1;
    localparam int LW = $clog2(MAX_KEY_LEN + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_LEFT, S_LCMP, S_RIGHT, S_RCMP, S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      count_reg, count_next;
    logic [31:0]           prim_acc_reg, prim_acc_next;
    logic [15:0]           sum_acc_reg, sum_acc_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [31:0]           ph_reg, ph_next;
    logic [31:0]           sh_reg, sh_next;
    logic [NW-1:0]         n_reg, n_next;
    logic signed [SW-1:0]  lo_reg, lo_next;
    logic signed [SW-1:0]  hi_reg, hi_next;
    logic signed [SW-1:0]  mid_reg, mid_next;
    logic signed [SW-1:0]  k_reg, k_next;
    logic                  res_found_reg, res_found_next;
    logic [11:0]           res_index_reg, res_index_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic [63:0]           table_mem [TABLE_DEPTH];
    logic [63:0]           rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;

    logic                  s_fire;
    logic [31:0]           byte_ext;
    logic [31:0]           prim_upd;
    logic [15:0]           sum_upd;
    logic [LW-1:0]         len_upd;
    logic [NW-1:0]         n_clip;
    logic signed [SW-1:0]  n_s;
    logic signed [SW-1:0]  mid_calc;
    logic                  rd_match;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_fire    = s_valid && s_ready;

    assign wr_en   = s_fire && (s_data.req_type == REQ_LOAD)
                     && (32'(s_data.entry_index) < TABLE_DEPTH);
    assign wr_addr = AW'(s_data.entry_index);

    assign byte_ext = {{24{s_data.key_byte[7]}}, s_data.key_byte};
    assign prim_upd = (prim_acc_reg << 5) + prim_acc_reg + byte_ext;
    assign sum_upd  = sum_acc_reg + byte_ext[15:0];
    assign len_upd  = (32'(len_reg) < MAX_KEY_LEN) ? len_reg + LW'(1) : len_reg;
    assign n_clip   = (32'(count_reg) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(count_reg);
    assign n_s      = $signed({1'b0, n_reg});
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign rd_match = (rd_data_reg[63:32] == ph_reg) && (rd_data_reg[31:0] == sh_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'($unsigned(mid_calc));
        case (state_reg)
            S_PROBE: begin
                rd_en = (lo_reg <= hi_reg);
            end
            S_LEFT: begin
                rd_en   = (k_reg >= 0);
                rd_addr = AW'($unsigned(k_reg));
            end
            S_RIGHT: begin
                rd_en   = (k_reg < n_s);
                rd_addr = AW'($unsigned(k_reg));
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= {s_data.entry_primary_hash, s_data.entry_secondary_hash};
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        prim_acc_next  = prim_acc_reg;
        sum_acc_next   = sum_acc_reg;
        len_next       = len_reg;
        ph_next        = ph_reg;
        sh_next        = sh_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_data.req_type == REQ_KEY)) begin
                    if (s_data.key_last) begin
                        // The key is complete: latch its hashes and start the search.
                        ph_next       = prim_upd;
                        sh_next       = {16'(len_upd), sum_upd};
                        n_next        = n_clip;
                        lo_next       = '0;
                        hi_next       = $signed({1'b0, n_clip}) - SW'(1);
                        prim_acc_next = DJB_SEED;
                        sum_acc_next  = '0;
                        len_next      = '0;
                        state_next    = S_PROBE;
                    end else begin
                        prim_acc_next = prim_upd;
                        sum_acc_next  = sum_upd;
                        len_next      = len_upd;
                    end
                end
            end
            S_PROBE: begin
                if (lo_reg <= hi_reg) begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end else begin
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    state_next     = S_EMIT;
                end
            end
            S_CMP: begin
                if (rd_data_reg[63:32] == ph_reg) begin
                    if (rd_data_reg[31:0] == sh_reg) begin
                        res_found_next = 1'b1;
                        res_index_next = 12'($unsigned(mid_reg));
                        state_next     = S_EMIT;
                    end else begin
                        // Primary hash collides: look at the neighbours on both sides.
                        k_next     = mid_reg - SW'(1);
                        state_next = S_LEFT;
                    end
                end else if (rd_data_reg[63:32] > ph_reg) begin
                    hi_next    = mid_reg - SW'(1);
                    state_next = S_PROBE;
                end else begin
                    lo_next    = mid_reg + SW'(1);
                    state_next = S_PROBE;
                end
            end
            S_LEFT: begin
                if (k_reg >= 0) begin
                    state_next = S_LCMP;
                end else begin
                    k_next     = mid_reg + SW'(1);
                    state_next = S_RIGHT;
                end
            end
            S_LCMP: begin
                if (rd_match) begin
                    res_found_next = 1'b1;
                    res_index_next = 12'($unsigned(k_reg));
                    state_next     = S_EMIT;
                end else begin
                    k_next     = k_reg - SW'(1);
                    state_next = S_LEFT;
                end
            end
            S_RIGHT: begin
                if (k_reg < n_s) begin
                    state_next = S_RCMP;
                end else begin
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    state_next     = S_EMIT;
                end
            end
            S_RCMP: begin
                if (rd_match) begin
                    res_found_next = 1'b1;
                    res_index_next = 12'($unsigned(k_reg));
                    state_next     = S_EMIT;
                end else begin
                    k_next     = k_reg + SW'(1);
                    state_next = S_RIGHT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.found          = res_found_reg;
                    m_data_next.match_index    = res_index_reg;
                    m_data_next.primary_hash   = ph_reg;
                    m_data_next.secondary_hash = sh_reg;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            prim_acc_reg <= DJB_SEED;
            sum_acc_reg  <= '0;
            len_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prim_acc_reg <= prim_acc_next;
            sum_acc_reg  <= sum_acc_next;
            len_reg      <= len_next;
            m_valid_reg  <= m_valid_next;
        end
        ph_reg        <= ph_next;
        sh_reg        <= sh_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        k_reg         <= k_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        m_data_reg    <= m_data_next;
    end

    // Handing over a result always leaves a valid item in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result lost on hand-over");

    // Every table read during a lookup stays inside the loaded entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> ((NW + 1)'(rd_addr) < (NW + 1)'(n_reg)))
        else $error("table read outside the loaded entries");

    // The key accumulators are back at their seed while a lookup runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (prim_acc_reg == DJB_SEED && sum_acc_reg == '0
                                   && len_reg == '0))
        else $error("accumulators not cleared for the next key");

endmodule

`default_nettype wire
